// ===== rtl/mspt_pkg.sv =====
// Shared types and constants for the multi-slot periodic timer.
`default_nettype none
package mspt_pkg;
	localparam int SLOTS  = 8;
	localparam int MASK_W = 8;
	localparam int TIME_W = 32;
	localparam int PER_W  = 24;
	localparam int SLOT_W = 3;
	localparam int MODE_W = 2;
	// slots that show up in the masks
	localparam int SHOWN  = (SLOTS < MASK_W) ? SLOTS : MASK_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_STOP  = 2'd2
	} mode_t;
endpackage
`default_nettype wire

// ===== rtl/multi_slot_periodic_timer.sv =====
// Top level of the multi-slot periodic timer.
//
// Usage: a table of SLOTS timer slots driven by a 32-bit millisecond
// counter that advances only on a tick. An item is presented on mode, slot,
// timeout and period with start high; it is taken at the rising edge where
// start is high and busy is low. busy is always low: the block takes an
// item in every cycle, one item per cycle sustained.
//   mode tick  : advance the counter, then fire every armed slot whose
//                expiry has been reached (wrap-safe signed difference);
//                periodic slots re-arm at now plus period, one-shots drop.
//   mode start : arm a slot at now plus timeout with the given period.
//   mode stop  : disarm a slot and clear its period.
// Timing: the item is registered in the input register at the accepting
// edge; the table is then updated and the result captured in the result
// register, which drives done, with fired_mask and enabled_mask valid for
// that one cycle. All slots are compared in parallel, one subtract and one
// add per slot.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (arst_n low) clears the counter, all enables and periods; expiry
// entries stay unwritten until a start arms their slot.
`default_nettype none
module multi_slot_periodic_timer
	import mspt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [SLOT_W-1:0] slot,
	input  wire logic [23:0]       timeout,
	input  wire logic [PER_W-1:0]  period,
	output logic                   done,
	output logic [MASK_W-1:0]      fired_mask,
	output logic [MASK_W-1:0]      enabled_mask
);
	// input register
	logic              valid_s1;
	logic [MODE_W-1:0] mode_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [23:0]       timeout_s1;
	logic [PER_W-1:0]  period_s1;

	// timer state
	logic [TIME_W-1:0] now_q;
	logic [SLOTS-1:0]  en_q;
	logic [TIME_W-1:0] expiry_q [SLOTS];
	logic [PER_W-1:0]  period_q [SLOTS];

	// next state
	logic [TIME_W-1:0] now_d;
	logic [SLOTS-1:0]  en_d;
	logic [TIME_W-1:0] expiry_d [SLOTS];
	logic [PER_W-1:0]  period_d [SLOTS];
	logic [SLOTS-1:0]  fired_d;

	// result register
	logic              done_q;
	logic [MASK_W-1:0] fired_q;
	logic [MASK_W-1:0] enabled_q;

	logic              accept;
	logic [TIME_W-1:0] now_inc;
	logic [TIME_W-1:0] start_exp;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= mode;
			slot_s1    <= slot;
			timeout_s1 <= timeout;
			period_s1  <= period;
		end
	end

	assign now_inc   = now_q + TIME_W'(1);
	assign start_exp = now_q + TIME_W'(timeout_s1);

	// one pass over all slots in parallel
	always_comb begin
		logic [TIME_W-1:0] diff;
		logic              sel;
		diff    = '0;
		sel     = 1'b0;
		now_d   = now_q;
		en_d    = en_q;
		fired_d = '0;
		for (int i = 0; i < SLOTS; i++) begin
			expiry_d[i] = expiry_q[i];
			period_d[i] = period_q[i];
		end
		if (valid_s1) begin
			case (mode_s1)
				MODE_TICK: begin
					now_d = now_inc;
					for (int i = 0; i < SLOTS; i++) begin
						diff = now_inc - expiry_q[i];
						if (en_q[i] && !diff[TIME_W-1]) begin
							fired_d[i] = 1'b1;
							if (period_q[i] != '0) begin
								expiry_d[i] = now_inc + TIME_W'(period_q[i]);
							end else begin
								en_d[i] = 1'b0;
							end
						end
					end
				end
				MODE_START: begin
					for (int i = 0; i < SLOTS; i++) begin
						sel = (32'(slot_s1) == i);
						if (sel) begin
							expiry_d[i] = start_exp;
							period_d[i] = period_s1;
							en_d[i]     = 1'b1;
						end
					end
				end
				MODE_STOP: begin
					for (int i = 0; i < SLOTS; i++) begin
						sel = (32'(slot_s1) == i);
						if (sel) begin
							period_d[i] = '0;
							en_d[i]     = 1'b0;
						end
					end
				end
				default: begin
					// unused mode: state holds
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q  <= '0;
			en_q   <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				period_q[i] <= '0;
			end
		end else begin
			now_q  <= now_d;
			en_q   <= en_d;
			done_q <= valid_s1;
			for (int i = 0; i < SLOTS; i++) begin
				period_q[i] <= period_d[i];
			end
		end
	end

	// expiry entries carry no reset: only read while their slot is armed
	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			expiry_q[i] <= expiry_d[i];
		end
		if (valid_s1) begin
			fired_q   <= MASK_W'(fired_d[SHOWN-1:0]);
			enabled_q <= MASK_W'(en_d[SHOWN-1:0]);
		end
	end

	assign done         = done_q;
	assign fired_mask   = done_q ? fired_q : '0;
	assign enabled_mask = enabled_q;

	// a registered item always yields exactly one result strobe
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 == $past(accept) ##0 1'b1 |=> done_q == $past(valid_s1))
		else $error("result strobe does not follow item");

	// only slots armed before the tick may fire
	a_fired_armed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> (fired_q & ~MASK_W'($past(en_q[SHOWN-1:0]))) == '0)
		else $error("unarmed slot fired");

	// start and stop touch no slot but their own in the masks they report
	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && mode_s1 == MODE_START && 32'(slot_s1) < SHOWN
		|=> enabled_mask[$past(slot_s1)] && fired_q == '0)
		else $error("start did not arm its slot");

	a_stop_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && mode_s1 == MODE_STOP && 32'(slot_s1) < SHOWN
		|=> !enabled_mask[$past(slot_s1)] && fired_q == '0)
		else $error("stop did not disarm its slot");

	// the counter moves only on a tick
	a_now_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && mode_s1 == MODE_TICK) |=> $stable(now_q))
		else $error("counter moved without a tick");
endmodule
`default_nettype wire
